// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/u8dec_pkg.sv =====
// types and constants of the utf-8 to ucs-2 decoder
`timescale 1ns / 1ps

package u8dec_pkg;

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;

  // following bytes still expected
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] code_point;
  } dec_result_t;

endpackage

// ===== rtl/utf8_to_ucs2_decoder.sv =====
// top level of the utf-8 to ucs-2 decoder
// takes one string byte per request and gives 16-bit code points of the basic
// multilingual plane: bytes up to 0x7f pass through, lead bytes 0xc2-0xdf and
// 0xe0-0xef open two- and three-byte sequences, and each following byte adds
// its low six bits without a check of its continuation marker. other lead
// bytes and sequences cut off by tlast give nothing, and tlast clears the
// sequence state. a byte goes from the input register through the decode
// logic into the result register in one step, so one byte per cycle is taken
// in sustained flow while results are taken; a code point is on the output
// once its byte has left the input register. a waiting result still lets the
// input register take one byte, and it stalls only when both registers are full
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte [7:0]
  input  logic        s_tlast,   // end_of_string
  // code point results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // code_point [15:0]
);

  logic        item_valid;
  in_item_t    item;
  dec_result_t result;
  logic        out_free;
  logic        advance;

  // held byte moves on when the result register can take its outcome
  assign advance = item_valid && out_free;

  // input register
  u8dec_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // sequence state and decode
  u8dec_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  // result register
  u8dec_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .result   (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/u8dec_in_reg.sv =====
// input register of the decoder, one request deep
`timescale 1ns / 1ps

module u8dec_in_reg
  import u8dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte [7:0]
  input  logic       s_tlast,   // end_of_string
  input  logic       advance,
  output logic       item_valid,
  output in_item_t   item
);

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.in_byte       <= s_tdata;
      item.end_of_string <= s_tlast;
    end
  end

endmodule

// ===== rtl/u8dec_core.sv =====
// sequence state and per-byte decode logic
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8dec_core
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  in_item_t    item,
  output dec_result_t result
);

  logic [1:0]  bytes_pending;
  logic [9:0]  partial_bits;
  logic [1:0]  bytes_pending_next;
  logic [9:0]  partial_bits_next;
  logic [15:0] acc;
  logic [7:0]  b;

  assign b   = item.in_byte;
  assign acc = {partial_bits, b[5:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_bits_next  = partial_bits;
    result.valid       = 1'b0;
    result.code_point  = 16'h0000;
    unique case (bytes_pending)
      PEND_NONE: begin
        priority if (b <= ASCII_MAX) begin
          result.valid      = 1'b1;
          result.code_point = {8'h00, b};
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          bytes_pending_next = PEND_ONE;
          partial_bits_next  = {5'b0, b[4:0]};
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          bytes_pending_next = PEND_TWO;
          partial_bits_next  = {6'b0, b[3:0]};
        end else begin
          // bad lead byte, dropped
          bytes_pending_next = PEND_NONE;
        end
      end
      PEND_ONE: begin
        result.valid       = 1'b1;
        result.code_point  = acc;
        bytes_pending_next = PEND_NONE;
        partial_bits_next  = 10'd0;
      end
      default: begin
        // two pending (three never occurs and acts the same)
        partial_bits_next  = acc[9:0];
        bytes_pending_next = PEND_ONE;
      end
    endcase
    if (item.end_of_string) begin
      bytes_pending_next = PEND_NONE;
      partial_bits_next  = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= PEND_NONE;
      partial_bits  <= 10'd0;
    end else if (advance) begin
      bytes_pending <= bytes_pending_next;
      partial_bits  <= partial_bits_next;
    end
  end

  `ASSERT_ALWAYS(a_pending_range, clk, rst, bytes_pending != 2'd3)
  `ASSERT_ALWAYS(a_idle_clear, clk, rst, (bytes_pending != PEND_NONE) || (partial_bits == 10'd0))
  `ASSERT_NEXT(a_end_clears, clk, rst, advance && item.end_of_string, bytes_pending == PEND_NONE)

endmodule

// ===== rtl/u8dec_out_reg.sv =====
// result register of the decoder
`timescale 1ns / 1ps

module u8dec_out_reg
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  dec_result_t result,
  output logic        out_free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // code_point [15:0]
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= result.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      m_tdata <= result.code_point;
    end
  end

endmodule
